// ----- hw/rtl/swvd_pkg.sv -----
package swvd_pkg;

    // Operation codes
    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_SEARCH = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    typedef logic [DATA_W-1:0] t_data;

    // Per-cell load control: take the neighbor above (push) or below (pop, delete)
    typedef struct packed {
        logic load_above;
        logic load_below;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/swvd_cell.sv -----
module swvd_cell (
    input  logic                 i_clk,
    input  swvd_pkg::t_cell_ctl  i_ctl,
    input  swvd_pkg::t_data      i_above,
    input  swvd_pkg::t_data      i_below,
    input  swvd_pkg::t_data      i_key,
    input  logic                 i_live,
    output swvd_pkg::t_data      o_data,
    output logic                 o_eq
);
    import swvd_pkg::*;

    t_data r_data;

    // Load from the neighbor that the operation selects, else hold
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_above) begin
            r_data <= i_above;
        end else if (i_ctl.load_below) begin
            r_data <= i_below;
        end
    end

    // Compare against the operation key; only held entries count
    assign o_eq   = i_live && (r_data == i_key);
    assign o_data = r_data;

endmodule

// ----- hw/rtl/swvd_find.sv -----
module swvd_find #(
    parameter int STACK_DEPTH = 16
) (
    input  logic [STACK_DEPTH-1:0]     i_eq,
    output logic [STACK_DEPTH-1:0]     o_at_or_below,
    output logic                       o_found,
    output logic [swvd_pkg::POS_W-1:0] o_position
);
    import swvd_pkg::*;

    logic [STACK_DEPTH-1:0] w_prefix;
    logic [STACK_DEPTH-1:0] w_first;

    // Ripple the match flag from top cell down to mark the first hit
    always_comb begin
        w_prefix[0] = i_eq[0];
        w_first[0]  = i_eq[0];
        for (int i = 1; i < STACK_DEPTH; i++) begin
            w_prefix[i] = w_prefix[i-1] | i_eq[i];
            w_first[i]  = i_eq[i] & ~w_prefix[i-1];
        end
    end

    // Encode the low bits of the first hit's depth
    always_comb begin
        o_position = '0;
        for (int b = 0; b < POS_W; b++) begin
            for (int i = 0; i < STACK_DEPTH; i++) begin
                if (((i >> b) & 1) == 1) begin
                    o_position[b] = o_position[b] | w_first[i];
                end
            end
        end
    end

    assign o_at_or_below = w_prefix;
    assign o_found       = w_prefix[STACK_DEPTH-1];

endmodule

// ----- hw/rtl/stack_with_value_delete_unit.sv -----
// An operand is registered on input transfer, then executes into the result
// register when that is free. Throughput: one operation per cycle while i_ready
// is high; all cells compare and shift in parallel, and the top-first match
// chain sets the execute cycle's path. Reset (i_rst_n low, synchronous) empties
// the stack and drops any pending operation or result; entries are not cleared.
module stack_with_value_delete_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_action,
    input  logic signed [31:0]           i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [31:0]           o_out_value,
    output logic                         o_found,
    output logic [swvd_pkg::POS_W-1:0]   o_position,
    output logic [1:0]                   o_status,
    output logic [swvd_pkg::COUNT_W-1:0] o_entry_count
);
    import swvd_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Operand register
    logic        r_busy;
    logic [1:0]  r_action;
    t_data       r_value;

    // Stack fill
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // Result register
    logic               r_out_valid;
    t_data              r_out_value;
    logic               r_out_found;
    logic [POS_W-1:0]   r_out_pos;
    logic [1:0]         r_out_status;
    logic [COUNT_W-1:0] r_out_count;
    t_data              n_out_value;
    logic               n_out_found;
    logic [POS_W-1:0]   n_out_pos;
    logic [1:0]         n_out_status;

    logic w_exec;
    logic w_in_xfer;
    logic w_empty;
    logic w_full;
    logic w_do_push;
    logic w_do_pop;
    logic w_do_del;
    logic [31:0] w_count32;

    t_data                   w_data [STACK_DEPTH];
    logic [STACK_DEPTH-1:0]  w_eq;
    logic [STACK_DEPTH-1:0]  w_at_or_below;
    logic                    w_found;
    logic [POS_W-1:0]        w_pos;

    // Execute when an operand waits and the result register is free
    assign w_exec    = r_busy && (!r_out_valid || i_ready);
    assign o_ready   = !r_busy || w_exec;
    assign w_in_xfer = i_valid && o_ready;

    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count == CW'(STACK_DEPTH));
    assign w_do_push = w_exec && (r_action == ACT_PUSH) && !w_full;
    assign w_do_pop  = w_exec && (r_action == ACT_POP) && !w_empty;
    assign w_do_del  = w_exec && (r_action == ACT_DELETE) && w_found;

    // Row of cells, cell 0 is the top of the stack
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        t_cell_ctl w_ctl;
        t_data     w_above;
        t_data     w_below;
        logic      w_live;

        assign w_ctl.load_above = w_do_push;
        assign w_ctl.load_below = w_do_pop || (w_do_del && w_at_or_below[g]);
        assign w_live           = (CW'(g) < r_count);

        if (g == 0) begin : g_top
            assign w_above = r_value;
        end else begin : g_mid
            assign w_above = w_data[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bot
            assign w_below = '0;
        end else begin : g_up
            assign w_below = w_data[g+1];
        end

        swvd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_above (w_above),
            .i_below (w_below),
            .i_key   (r_value),
            .i_live  (w_live),
            .o_data  (w_data[g]),
            .o_eq    (w_eq[g])
        );
    end

    swvd_find #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_find (
        .i_eq          (w_eq),
        .o_at_or_below (w_at_or_below),
        .o_found       (w_found),
        .o_position    (w_pos)
    );

    // Result fields and next fill
    always_comb begin
        n_count      = r_count;
        n_out_value  = '0;
        n_out_found  = 1'b0;
        n_out_pos    = '0;
        n_out_status = ST_OK;
        case (r_action)
            ACT_PUSH: begin
                if (w_full) begin
                    n_out_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            ACT_POP: begin
                if (w_empty) begin
                    n_out_status = ST_EMPTY;
                end else begin
                    n_count     = r_count - CW'(1);
                    n_out_value = w_data[0];
                end
            end
            ACT_DELETE, ACT_SEARCH: begin
                if (w_empty) begin
                    n_out_status = ST_EMPTY;
                end else if (!w_found) begin
                    n_out_status = ST_MISSING;
                end else begin
                    n_out_value = r_value;
                    n_out_found = 1'b1;
                    n_out_pos   = w_pos;
                    if (r_action == ACT_DELETE) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign w_count32 = 32'(n_count);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture operand on input transfer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
    end

    // Capture result on execute
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out_value  <= n_out_value;
            r_out_found  <= n_out_found;
            r_out_pos    <= n_out_pos;
            r_out_status <= n_out_status;
            r_out_count  <= w_count32[COUNT_W-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_found       = r_out_found;
    assign o_position    = r_out_pos;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

endmodule

// ----- tb/tb_stack_with_value_delete_unit.sv -----
module tb_stack_with_value_delete_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import swvd_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int DIR_ROWS    = 25;
    localparam int RAND_ITEMS  = 1875;
    localparam int QUIET_ITEMS = 200;
    localparam int DRAIN_AT    = 900;
    localparam int HOLD_AFTER  = 400;
    localparam int LONG_HOLD   = 120;
    localparam int MAX_PRINTS  = 20;

    typedef struct packed {
        t_data              value;
        logic               found;
        logic [POS_W-1:0]   position;
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
    } t_stack_result;

    typedef struct packed {
        logic [1:0]    act;
        t_data         val;
        logic          fixed;
        t_stack_result want;
    } t_dir_row;

    localparam t_stack_result NO_RES = '0;

    // Directed rows: empty-stack ops, fill to full with extremes and duplicates,
    // overflow push, then matches at top, middle and bottom plus a miss
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{ACT_POP,    32'h0000_0000, 1'b1, '{32'h0, 1'b0, 4'd0, ST_EMPTY, 5'd0}},
        '{ACT_DELETE, 32'h0000_0005, 1'b1, '{32'h0, 1'b0, 4'd0, ST_EMPTY, 5'd0}},
        '{ACT_SEARCH, 32'h0000_0005, 1'b1, '{32'h0, 1'b0, 4'd0, ST_EMPTY, 5'd0}},
        '{ACT_PUSH,   32'h7fff_ffff, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd1}},
        '{ACT_PUSH,   32'h8000_0000, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd2}},
        '{ACT_PUSH,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd3}},
        '{ACT_PUSH,   32'hffff_ffff, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd4}},
        '{ACT_PUSH,   32'h0000_0001, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd5}},
        '{ACT_PUSH,   32'h5555_5555, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd6}},
        '{ACT_PUSH,   32'haaaa_aaaa, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd7}},
        '{ACT_PUSH,   32'h0000_0007, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd8}},
        '{ACT_PUSH,   32'h0000_0003, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd9}},
        '{ACT_PUSH,   32'h0000_0007, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd10}},
        '{ACT_PUSH,   32'h0000_0004, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd11}},
        '{ACT_PUSH,   32'h0000_0005, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd12}},
        '{ACT_PUSH,   32'h0000_0006, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd13}},
        '{ACT_PUSH,   32'h0000_0008, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd14}},
        '{ACT_PUSH,   32'h0000_0009, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd15}},
        '{ACT_PUSH,   32'h0000_000a, 1'b1, '{32'h0, 1'b0, 4'd0, ST_OK, 5'd16}},
        '{ACT_PUSH,   32'h0000_000b, 1'b1, '{32'h0, 1'b0, 4'd0, ST_FULL, 5'd16}},
        '{ACT_SEARCH, 32'h0000_0007, 1'b0, NO_RES},
        '{ACT_DELETE, 32'h8000_0000, 1'b0, NO_RES},
        '{ACT_DELETE, 32'h7fff_ffff, 1'b0, NO_RES},
        '{ACT_SEARCH, 32'h0001_2345, 1'b0, NO_RES},
        '{ACT_DELETE, 32'h0000_000a, 1'b0, NO_RES}
    };

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_action = ACT_PUSH;
    logic signed [31:0] i_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_out_value;
    logic               o_found;
    logic [POS_W-1:0]   o_position;
    logic [1:0]         o_status;
    logic [COUNT_W-1:0] o_entry_count;

    // Predicted stack contents and run bookkeeping
    t_data         stack_mem [STACK_DEPTH];
    int            stack_fill;
    t_stack_result pending_results [$];
    int            error_count;
    int            items_sent;
    int            results_seen;
    int            op_count [4];
    int            full_hits;
    int            empty_hits;
    int            match_hits;
    bit            quiet_phase;
    bit            long_hold_done;

    stack_with_value_delete_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_value   (o_out_value),
        .o_found       (o_found),
        .o_position    (o_position),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    // Clock generation
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one operation to the predicted stack and return its result
    function automatic t_stack_result predict_stack_op(input logic [1:0] act,
                                                       input t_data val);
        t_stack_result r;
        int            hit;
        int            i;
        r      = '0;
        r.status = ST_OK;
        hit    = -1;
        op_count[act]++;
        case (act)
            ACT_PUSH: begin
                if (stack_fill >= STACK_DEPTH) begin
                    r.status = ST_FULL;
                    full_hits++;
                end else begin
                    stack_mem[stack_fill] = val;
                    stack_fill++;
                end
            end
            ACT_POP: begin
                if (stack_fill == 0) begin
                    r.status = ST_EMPTY;
                    empty_hits++;
                end else begin
                    stack_fill--;
                    r.value = stack_mem[stack_fill];
                end
            end
            default: begin
                if (stack_fill == 0) begin
                    r.status = ST_EMPTY;
                    empty_hits++;
                end else begin
                    // Scan from the top for the first match
                    for (i = stack_fill - 1; i >= 0 && hit < 0; i--) begin
                        if (stack_mem[i] == val) hit = i;
                    end
                    if (hit < 0) begin
                        r.status = ST_MISSING;
                    end else begin
                        match_hits++;
                        r.value    = val;
                        r.found    = 1'b1;
                        r.position = POS_W'(stack_fill - 1 - hit);
                        // Close the gap: entries above the match move down one
                        if (act == ACT_DELETE) begin
                            for (i = hit; i < stack_fill - 1; i++) begin
                                stack_mem[i] = stack_mem[i + 1];
                            end
                            stack_fill--;
                        end
                    end
                end
            end
        endcase
        r.count = COUNT_W'(stack_fill);
        return r;
    endfunction

    // Pick an operation; the mode tilts the stack toward full or toward empty
    function automatic logic [1:0] pick_action(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0:       return (r < 55) ? ACT_PUSH : (r < 70) ? ACT_POP :
                            (r < 85) ? ACT_DELETE : ACT_SEARCH;
            1:       return (r < 25) ? ACT_PUSH : (r < 60) ? ACT_POP :
                            (r < 85) ? ACT_DELETE : ACT_SEARCH;
            default: return (r < 35) ? ACT_PUSH : (r < 55) ? ACT_POP :
                            (r < 80) ? ACT_DELETE : ACT_SEARCH;
        endcase
    endfunction

    // Pick a value: small pool for duplicates, extremes, held values, or anything
    function automatic t_data pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return t_data'($urandom_range(0, 7));
        if (r == 4) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7fff_ffff;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        if (r < 7 && stack_fill > 0) return stack_mem[$urandom_range(0, stack_fill - 1)];
        return $urandom;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
    endtask

    // Offer one operation, hold it until transfer, then maybe drop valid for a burst
    task automatic send_op(input logic [1:0] act, input t_data val, input t_stack_result want);
        i_valid  <= 1'b1;
        i_action <= act;
        i_value  <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(want);
        items_sent++;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Stimulus: reset, directed table, then random operations
    initial begin
        t_stack_result predicted;
        logic [1:0]    act;
        int            mode;
        int            mode_left;
        stack_fill = 0;
        mode       = 2;
        mode_left  = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++) begin
            predicted = predict_stack_op(DIR_TABLE[k].act, DIR_TABLE[k].val);
            send_op(DIR_TABLE[k].act, DIR_TABLE[k].val,
                    DIR_TABLE[k].fixed ? DIR_TABLE[k].want : predicted);
        end

        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (k >= RAND_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;
            act = pick_action(mode);
            if (act == ACT_POP) begin
                predicted = predict_stack_op(act, $urandom);
                send_op(act, $urandom, predicted);
            end else begin
                t_data val;
                val       = pick_value();
                predicted = predict_stack_op(act, val);
                send_op(act, val, predicted);
            end
            // Pause the sender until every outstanding result is back
            if (k == DRAIN_AT) begin
                i_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Ran %0d operations: %0d push, %0d pop, %0d delete, %0d search",
                 items_sent, op_count[ACT_PUSH], op_count[ACT_POP],
                 op_count[ACT_DELETE], op_count[ACT_SEARCH]);
        $display("Checked %0d results; full stack %0d, empty stack %0d, value match %0d",
                 results_seen, full_hits, empty_hits, match_hits);
        if (error_count == 0) begin
            $display("stack_with_value_delete_unit verification clean");
        end else begin
            $display("stack_with_value_delete_unit verification failed");
        end
        $finish;
    end

    // Result sink: random stall bursts, one long hold-off, steady ready at the end
    initial begin
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && items_sent >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else if (quiet_phase) begin
                i_ready <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 24) - 1) @(posedge i_clk);
            end
        end
    end

    // Compare each result transfer with the oldest pending prediction
    always @(posedge i_clk) begin : result_check
        t_stack_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no operation pending", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_value !== want.value)
                    report_mismatch("out_value", o_out_value, want.value);
                if (o_found !== want.found)
                    report_mismatch("found", o_found, want.found);
                if (o_position !== want.position)
                    report_mismatch("position", o_position, want.position);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_entry_count !== want.count)
                    report_mismatch("entry_count", o_entry_count, want.count);
            end
        end
    end

    // Watchdog
    initial begin
        #(2_000_000);
        $display("stack_with_value_delete_unit verification failed");
        $finish;
    end

endmodule
